/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

/* hdl/ppt_pkg.sv */
`default_nettype none
package ppt_pkg;

  localparam int unsigned Q_W = 20;
  localparam logic [Q_W-1:0] Q_MAX = '1;

  typedef struct packed {
    logic [15:0] pixel_index;
    logic [15:0] raw_value;
    logic        pixel_hit;
  } ppt_req_t;

  typedef struct packed {
    logic [Q_W-1:0] mean_q4;
    logic [Q_W-1:0] rms_q4;
    logic           stats_valid;
    logic           updated;
  } ppt_res_t;

endpackage
`default_nettype wire

/* hdl/pixel_pedestal_tracker_core.sv */
`default_nettype none
// skips the dividers when the pixel is empty or out of range, and the square root when the variance is not positive
// one request at a time: busy stays high from accept through done, over the bit-serial dividers
// on the shifted sum and sum of squares followed by the bit-serial square root
// done is a one-cycle strobe; the receiver cannot stall it
// reset: synchronous; then a clearing pass over all PIXEL_COUNT entries with busy high
module pixel_pedestal_tracker_core
  import ppt_pkg::*;
#(
  parameter int PIXEL_COUNT = 65536,
  parameter int WINDOW = 1024
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire ppt_req_t req,
  output logic          busy,
  input  wire logic     cfg_we,
  input  wire logic     cfg_data,
  output logic          done,
  output ppt_res_t      result
);

  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam int CW = $clog2(WINDOW + 1);
  localparam int LW = $clog2(WINDOW);
  localparam int SW = LW + 16;
  localparam int SQW = LW + 32;
  localparam int QMW = SW + 4;
  localparam int QSW = SQW + 8;
  localparam int RW = (QSW + 1) / 2;
  localparam int VW = 2 * RW;
  localparam int MW = CW + SW + SQW;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_SQS  = 3'd5;
  localparam logic [2:0] S_SQ   = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]      state;
  logic            mode;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   addr;
  logic [15:0]     x;
  logic            hit;
  logic            in_range;
  logic [CW-1:0]   cnt;
  logic [SW-1:0]   sum;
  logic [SQW-1:0]  sq;
  logic [31:0]     xx;
  logic [Q_W-1:0]  mean;
  logic [2*Q_W-1:0] m2;
  logic [Q_W-1:0]  rms;
  logic            valid;
  logic            upd;

  logic            accept;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [MW-1:0]   wdata;
  logic [AW-1:0]   raddr;
  logic [MW-1:0]   rdata;
  logic [CW-1:0]   rd_cnt;
  logic [SW-1:0]   rd_sum;
  logic [SQW-1:0]  rd_sq;
  logic            div_start;
  logic [QMW-1:0]  qm;
  logic [QSW-1:0]  qs;
  logic            dm_busy;
  logic            ds_busy;
  logic            sq_start;
  logic [VW-1:0]   sq_in;
  logic [RW-1:0]   root;
  logic            sq_busy;
  logic            gt;
  logic [CW-1:0]   cnt_next;
  logic [SW-1:0]   sum_next;
  logic [SQW-1:0]  sq_next;
  logic [SW:0]     sum_add;
  logic [SQW:0]    sq_add;

  assign accept = start && !busy;
  assign busy = state != S_IDLE;
  assign raddr = AW'(req.pixel_index);
  assign {rd_cnt, rd_sum, rd_sq} = rdata;
  assign div_start = (state == S_LOAD) && in_range && (rd_cnt != '0);
  assign gt = VW'(qs) > VW'(m2);
  assign sq_start = (state == S_SQS) && gt;
  assign sq_in = VW'(qs) - VW'(m2);

  // fold in the sample, or decay once the window is full
  assign sum_add = (SW+1)'(sum) + (SW+1)'(x);
  assign sq_add = (SQW+1)'(sq) + (SQW+1)'(xx);
  always_comb begin
    if (cnt < CW'(WINDOW)) begin
      cnt_next = cnt + 1'b1;
      sum_next = SW'(sum_add);
      sq_next = SQW'(sq_add);
    end else begin
      cnt_next = cnt;
      sum_next = SW'(sum_add - (SW+1)'(qm >> 4));
      sq_next = SQW'(sq_add - (SQW+1)'(qs >> 8));
    end
  end

  always_comb begin
    if (state == S_CLR) begin
      we = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we = (state == S_OUT) && upd;
      waddr = addr;
      wdata = {cnt_next, sum_next, sq_next};
    end
  end

  ppt_ram #(.W(MW), .D(PIXEL_COUNT), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  ppt_div #(.NW(QMW), .DW(CW)) u_div_mean (
    .clk(clk), .rst(rst), .start(div_start), .dividend({rd_sum, 4'b0000}),
    .divisor(rd_cnt), .quotient(qm), .busy(dm_busy)
  );

  ppt_div #(.NW(QSW), .DW(CW)) u_div_sq (
    .clk(clk), .rst(rst), .start(div_start), .dividend({rd_sq, 8'b00000000}),
    .divisor(rd_cnt), .quotient(qs), .busy(ds_busy)
  );

  ppt_sqrt #(.RW(RW)) u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .value(sq_in), .root(root), .busy(sq_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_we) begin
      mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_addr <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(PIXEL_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            addr <= raddr;
            x <= req.raw_value;
            hit <= req.pixel_hit;
            in_range <= 32'(req.pixel_index) < PIXEL_COUNT;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt <= rd_cnt;
          sum <= rd_sum;
          sq <= rd_sq;
          xx <= x * x;
          upd <= in_range && (mode || !hit);
          valid <= div_start;
          mean <= '0;
          rms <= '0;
          state <= div_start ? S_DIV : S_OUT;
          done <= !div_start;
        end
        S_DIV: begin
          if (!dm_busy && !ds_busy) begin
            mean <= (|qm[QMW-1:Q_W]) ? Q_MAX : qm[Q_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          m2 <= mean * mean;
          state <= S_SQS;
        end
        S_SQS: begin
          state <= gt ? S_SQ : S_OUT;
          done <= !gt;
        end
        S_SQ: begin
          if (!sq_busy) begin
            rms <= (|root[RW-1:Q_W]) ? Q_MAX : root[Q_W-1:0];
            state <= S_OUT;
            done <= 1'b1;
          end
        end
        S_OUT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign result.mean_q4 = mean;
  assign result.rms_q4 = rms;
  assign result.stats_valid = valid;
  assign result.updated = upd;

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_done_idle, done, !busy, "not idle after done")
  `ASSERT_NEXT(a_accept_busy, accept, busy, "not busy after accept")
  `ASSERT_NOW(a_empty_zero, done && !result.stats_valid,
    result.mean_q4 == '0 && result.rms_q4 == '0, "empty pixel reported nonzero")
  `ASSERT_NOW(a_done_out, done, state == S_OUT, "done outside output state")

endmodule
`default_nettype wire

/* hdl/ppt_ram.sv */
`default_nettype none
module ppt_ram #(
  parameter int W = 8,
  parameter int D = 16,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hdl/ppt_div.sv */
`default_nettype none
module ppt_div #(
  parameter int NW = 30,
  parameter int DW = 11
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic      [NW-1:0] quotient,
  output logic               busy
);

  localparam int KW = $clog2(NW + 1);

  logic [NW-1:0] n;
  logic [DW-1:0] d;
  logic [DW-1:0] rem;
  logic [KW-1:0] cnt;
  logic [DW:0]   trial;
  logic          ge;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, n[NW-1]};
  assign ge = trial >= {1'b0, d};
  assign quotient = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= KW'(NW);
      n <= dividend;
      d <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, d}) : DW'(trial);
      n <= {n[NW-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == KW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_div_busy, start, busy, "divider not busy after start")
  `ASSERT_NOW(a_div_cnt, busy, cnt != '0, "divider busy with zero count")

endmodule
`default_nettype wire

/* hdl/ppt_sqrt.sv */
`default_nettype none
module ppt_sqrt #(
  parameter int RW = 25
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [2*RW-1:0] value,
  output logic      [RW-1:0]   root,
  output logic                 busy
);

  localparam int KW = $clog2(RW + 1);

  logic [2*RW-1:0] v;
  logic [RW:0]     rem;
  logic [KW-1:0]   cnt;
  logic [RW+2:0]   cur;
  logic [RW+2:0]   trial;
  logic            ge;

  // digit-by-digit root, one result bit per cycle
  assign cur = {rem, v[2*RW-1:2*RW-2]};
  assign trial = (RW+3)'({root, 2'b01});
  assign ge = cur >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= KW'(RW);
      v <= value;
      rem <= '0;
      root <= '0;
    end else if (busy) begin
      rem <= ge ? (RW+1)'(cur - trial) : (RW+1)'(cur);
      root <= {root[RW-2:0], ge};
      v <= {v[2*RW-3:0], 2'b00};
      cnt <= cnt - 1'b1;
      if (cnt == KW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_sq_busy, start, busy, "sqrt not busy after start")

endmodule
`default_nettype wire
